// ===== hw/rtl/tht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tht_pkg: shared types and constants for the TTL hop table
// Slot geometry, hash constant, command codes and the slot memory interface.
// ----------------------------------------------------------------------------
package tht_pkg;

    // Table depth; the slot index is the low bits of the hash, so keep it a power of two
    localparam int unsigned SLOT_COUNT = 1024;
    localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);

    // Multiplier of the xor-shift-multiply hash
    localparam logic [31:0] HASH_MULT = 32'h045d9f3b;

    // Command codes carried in the input tuser
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic [IDX_W-1:0] slot_idx_t;

    // One table slot: valid flag, source address, last TTL
    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [7:0]  ttl;
    } slot_entry_t;

    // Access request from the control logic to the slot memory
    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        slot_idx_t   idx;
        slot_entry_t wdata;
    } mem_req_t;

endpackage

// ===== hw/rtl/tht_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tht_hash: slot index hash
// xor-shift, multiply, xor-shift; the product is registered on load and the
// final mix and index select follow in the next cycle.
// ----------------------------------------------------------------------------
module tht_hash (
    input  logic              clk,
    input  logic              load,
    input  logic [31:0]       address,
    output tht_pkg::slot_idx_t idx
);
    import tht_pkg::*;

    logic [31:0] mix;
    logic [31:0] prod_next;
    logic [31:0] prod_reg;
    logic [31:0] mixed;

    // First mix and multiply, modulo 2^32
    assign mix       = address ^ (address >> 16);
    assign prod_next = 32'(mix * HASH_MULT);

    // Product register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Second mix; low bits select the slot
    assign mixed = prod_reg ^ (prod_reg >> 16);
    assign idx   = mixed[IDX_W-1:0];

endmodule

// ===== hw/rtl/tht_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tht_slot_mem: slot storage
// Single-port synchronous memory of slot entries with a registered read.
// After reset a sweep clears every valid flag, one slot per cycle.
// ----------------------------------------------------------------------------
module tht_slot_mem (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tht_pkg::mem_req_t    req,
    output tht_pkg::slot_entry_t rdata,
    output logic                 clear_busy
);
    import tht_pkg::*;

    slot_entry_t mem [SLOT_COUNT];
    slot_entry_t rdata_reg;
    slot_idx_t   clr_idx_reg;
    logic        clr_active_reg;

    logic        wr_en;
    slot_idx_t   wr_idx;
    slot_entry_t wr_data;

    // Clear sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg    <= '0;
            clr_active_reg <= 1'b1;
        end
        else if (clr_active_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == slot_idx_t'(SLOT_COUNT - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Sweep owns the write port while active
    always_comb
    begin
        if (clr_active_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = clr_idx_reg;
            wr_data = '{valid: 1'b0, address: '0, ttl: '0};
        end
        else
        begin
            wr_en   = req.wr_en;
            wr_idx  = req.idx;
            wr_data = req.wdata;
        end
    end

    // Memory array, one access per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.idx];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clr_active_reg;

    // Control logic must stay off the memory during the sweep
    a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!req.wr_en && !req.rd_en))
        else $error("slot memory accessed during clear sweep");

    // Sweep ends exactly after the last slot
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> $past(clr_idx_reg == slot_idx_t'(SLOT_COUNT - 1)))
        else $error("clear sweep ended early");

endmodule

// ===== hw/rtl/ttl_hop_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_hop_table: direct-mapped table of IPv4 source addresses and last TTL
// Record beats overwrite the hashed slot; query beats return found and hops.
// Sequence: a record writes its slot in the access state after acceptance; a query
//   is read in the access state and its result registered in the check state
//   once the output is free. Input: a new beat is taken only back in idle, so
//   items are serialized through hash, access and, for a query, compare.
// Reset: clears enabled and the output; a clear sweep then invalidates every
//   slot, and no input beat is taken during it.
// ----------------------------------------------------------------------------
module ttl_hop_table (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write: enabled
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] address, [39:32] ttl
    input  logic [1:0]  s_tuser,   // [0] cmd, [1] is_ipv4
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] hops, [7] zero
    output logic        m_tuser    // [0] found
);
    import tht_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_CHECK
    } state_t;

    state_t      state_reg;
    logic        enabled_reg;
    logic        m_tvalid_reg;
    logic        found_reg;
    logic [6:0]  hops_reg;

    logic        item_cmd_reg;
    logic [31:0] item_addr_reg;
    logic [7:0]  item_ttl_reg;
    logic        item_v4_reg;

    logic        in_beat;
    logic        out_free;
    logic        clear_busy;
    slot_idx_t   idx;
    mem_req_t    req;
    slot_entry_t rdata;

    logic        hit;
    logic [7:0]  hop_start;
    logic [7:0]  hop_dist;
    logic        found_next;
    logic [6:0]  hops_next;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            enabled_reg <= cfg_data;
        end
    end

    // Input handshake
    assign s_tready = (state_reg == ST_IDLE) && !clear_busy;
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Item payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            item_cmd_reg  <= s_tuser[0];
            item_addr_reg <= s_tdata[31:0];
            item_ttl_reg  <= s_tdata[39:32];
            item_v4_reg   <= s_tuser[1];
        end
    end

    tht_hash u_hash (
        .clk     (clk),
        .load    (in_beat),
        .address (s_tdata[31:0]),
        .idx     (idx)
    );

    // Memory access; items are serialized so a write never overlaps a read
    always_comb
    begin
        req.rd_en = (state_reg == ST_ACCESS) && (item_cmd_reg == CMD_QUERY);
        req.wr_en = (state_reg == ST_ACCESS) && (item_cmd_reg == CMD_RECORD);
        req.idx   = idx;
        req.wdata = '{valid: 1'b1, address: item_addr_reg, ttl: item_ttl_reg};
    end

    tht_slot_mem u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rdata      (rdata),
        .clear_busy (clear_busy)
    );

    // Hit test and hop distance from the stored TTL
    always_comb
    begin
        hit = enabled_reg && item_v4_reg && rdata.valid && (rdata.address == item_addr_reg);
        if (rdata.ttl <= 8'd64)
        begin
            hop_start = 8'd64;
        end
        else if (rdata.ttl <= 8'd128)
        begin
            hop_start = 8'd128;
        end
        else
        begin
            hop_start = 8'd255;
        end
        hop_dist   = hop_start - rdata.ttl;
        found_next = hit && (hop_dist != 8'd0) && (hop_dist <= 8'd64);
        hops_next  = found_next ? hop_dist[6:0] : 7'd0;
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
            hops_reg     <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= ST_ACCESS;
                    end
                end
                ST_ACCESS:
                begin
                    state_reg <= (item_cmd_reg == CMD_QUERY) ? ST_CHECK : ST_IDLE;
                end
                ST_CHECK:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        found_reg    <= found_next;
                        hops_reg     <= hops_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, hops_reg};
    assign m_tuser  = found_reg;

    // A query beat goes to the memory access and then the compare
    a_query_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_tuser[0] == CMD_QUERY) |=> state_reg == ST_ACCESS ##1
            state_reg == ST_CHECK)
        else $error("query did not follow access and compare");

    // A record beat returns to idle without producing a result
    a_record_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_tuser[0] == CMD_RECORD) |=> ##1
            (state_reg == ST_IDLE && !$rose(m_tvalid_reg)))
        else $error("record produced a result or stalled");

    // New results come only out of the compare step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_CHECK))
        else $error("result raised outside compare");

    // Found implies a distance in range; not found implies zero
    a_hops_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> ((found_reg && hops_reg != 7'd0 && hops_reg <= 7'd64) ||
                          (!found_reg && hops_reg == 7'd0)))
        else $error("hops out of range for found flag");

    // No input beat during the clear sweep
    a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !s_tready)
        else $error("input taken during clear sweep");

endmodule
